>>> src/rc4_pkg.sv
// rc4_pkg: shared types and constants for the rc4 stream cipher
// controller state, datapath operation codes, command and status structs
// no dependencies
package rc4_pkg;

  localparam int unsigned PERM_DEPTH   = 256;
  localparam int unsigned PERM_AW      = $clog2(PERM_DEPTH);
  localparam int unsigned KEY_BYTES_DEF = 16;
  localparam int unsigned KEY_BYTES_MAX = 16;
  localparam int unsigned KEY_IDX_W    = $clog2(KEY_BYTES_MAX);
  localparam int unsigned KEY_W        = 8 * KEY_BYTES_MAX;

  // apb register map, one 64-bit register every 8 bytes
  localparam int unsigned APB_AW       = 4;
  localparam logic        REG_KEY_LOW  = 1'b0;
  localparam logic        REG_KEY_HIGH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_INIT,
    ST_KS_RDI,
    ST_KS_RDJ,
    ST_KS_WRI,
    ST_KS_WRJ,
    ST_P_RDX,
    ST_P_RDY,
    ST_P_SWX,
    ST_P_SWY,
    ST_P_HOLD
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,    // S[i] = i
    OP_RD_I,    // read S[i]
    OP_KS_J,    // j += S[i] + key, read S[j]
    OP_KS_WI,   // S[i] = S[j]
    OP_KS_WJ,   // S[j] = old S[i]
    OP_RD_X,    // x += 1, read S[x]
    OP_P_Y,     // y += S[x], read S[y]
    OP_P_WX,    // S[x] = S[y], read S[t]
    OP_P_WY     // S[y] = old S[x], form keystream
  } op_t;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic idx_clear;
    logic i_clear;
    logic i_step;
    op_t  op;
    logic out_load;
    logic out_held;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic out_free;
    logic i_last;
  } sts_t;

endpackage

>>> src/rc4_ctrl.sv
// rc4_ctrl: sequencing state machine for key scheduling and keystream steps
// depends on rc4_pkg
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   pending, pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b1;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    state_next   = state;
    pending_next = pending;
    cmd          = '0;
    cmd.op       = OP_NONE;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load_in  = 1'b1;
          pending_next = sts.in_last;
          if (pending) begin
            cmd.idx_clear = 1'b1;
            cmd.i_clear   = 1'b1;
            state_next    = ST_KS_INIT;
          end else begin
            cmd.op     = OP_RD_X;
            state_next = ST_P_RDY;
          end
        end
      end
      ST_KS_INIT: begin
        cmd.op     = OP_INIT;
        cmd.i_step = 1'b1;
        if (sts.i_last) state_next = ST_KS_RDI;
      end
      ST_KS_RDI: begin
        cmd.op     = OP_RD_I;
        state_next = ST_KS_RDJ;
      end
      ST_KS_RDJ: begin
        cmd.op     = OP_KS_J;
        state_next = ST_KS_WRI;
      end
      ST_KS_WRI: begin
        cmd.op     = OP_KS_WI;
        state_next = ST_KS_WRJ;
      end
      ST_KS_WRJ: begin
        cmd.op     = OP_KS_WJ;
        cmd.i_step = 1'b1;
        if (sts.i_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = ST_P_RDX;
        end else begin
          state_next = ST_KS_RDI;
        end
      end
      ST_P_RDX: begin
        cmd.op     = OP_RD_X;
        state_next = ST_P_RDY;
      end
      ST_P_RDY: begin
        cmd.op     = OP_P_Y;
        state_next = ST_P_SWX;
      end
      ST_P_SWX: begin
        cmd.op     = OP_P_WX;
        state_next = ST_P_SWY;
      end
      ST_P_SWY: begin
        cmd.op = OP_P_WY;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_P_HOLD;
        end
      end
      ST_P_HOLD: begin
        cmd.out_held = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> src/rc4_datapath.sv
// rc4_datapath: permutation memory, indices, swap registers and result logic
// depends on rc4_pkg, driven by rc4_ctrl commands
module rc4_datapath
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [KEY_W-1:0] key,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             i_last,
  output logic [7:0]       res_byte,
  output logic             res_last
);

  localparam logic [KEY_IDX_W-1:0] KIDX_LAST = KEY_IDX_W'(KEY_BYTES - 1);

  logic [7:0] perm_mem [PERM_DEPTH];
  logic [PERM_AW-1:0] raddr, waddr;
  logic [7:0]         wdata, rdata;
  logic               we;

  logic [PERM_AW-1:0]   x, y, i, t;
  logic [PERM_AW-1:0]   y_next;
  logic [KEY_IDX_W-1:0] kidx;
  logic [7:0]           s_a, s_b, data_reg, res_reg, ks, key_sel;
  logic                 last_reg;
  logic [KEY_W-1:0]     key_shift;

  always_ff @(posedge clk) begin
    if (we) perm_mem[waddr] <= wdata;
    rdata <= perm_mem[raddr];
  end

  assign key_shift = key >> {kidx, 3'b000};
  assign key_sel   = key_shift[7:0];
  assign i_last    = (i == PERM_AW'(PERM_DEPTH - 1));

  // keystream byte with forwarding of the swap written around the read of S[t]
  always_comb begin
    if (t == y)      ks = s_a;
    else if (t == x) ks = s_b;
    else             ks = rdata;
  end

  always_comb begin
    raddr  = '0;
    waddr  = '0;
    wdata  = '0;
    we     = 1'b0;
    y_next = y;
    case (cmd.op)
      OP_INIT: begin
        we    = 1'b1;
        waddr = i;
        wdata = i;
      end
      OP_RD_I: raddr = i;
      OP_KS_J: begin
        y_next = 8'(y + rdata + key_sel);
        raddr  = y_next;
      end
      OP_KS_WI: begin
        we    = 1'b1;
        waddr = i;
        wdata = rdata;
      end
      OP_KS_WJ: begin
        we    = 1'b1;
        waddr = y;
        wdata = s_a;
      end
      OP_RD_X: raddr = 8'(x + 8'd1);
      OP_P_Y: begin
        y_next = 8'(y + rdata);
        raddr  = y_next;
      end
      OP_P_WX: begin
        we    = 1'b1;
        waddr = x;
        wdata = rdata;
        raddr = 8'(s_a + rdata);
      end
      OP_P_WY: begin
        we    = 1'b1;
        waddr = y;
        wdata = s_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      i    <= '0;
      kidx <= '0;
    end else begin
      if (cmd.idx_clear) begin
        x <= '0;
        y <= '0;
      end else begin
        y <= y_next;
        if (cmd.op == OP_RD_X) x <= 8'(x + 8'd1);
      end
      if (cmd.i_clear) begin
        i    <= '0;
        kidx <= '0;
      end else begin
        if (cmd.i_step) i <= 8'(i + 8'd1);
        if (cmd.op == OP_KS_J) kidx <= (kidx == KIDX_LAST) ? '0 : KEY_IDX_W'(kidx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      data_reg <= in_byte;
      last_reg <= in_last;
    end
    if (cmd.op == OP_KS_J || cmd.op == OP_P_Y) s_a <= rdata;
    if (cmd.op == OP_P_WX) begin
      s_b <= rdata;
      t   <= 8'(s_a + rdata);
    end
    if (cmd.op == OP_P_WY) res_reg <= data_reg ^ ks;
  end

  assign res_byte = cmd.out_held ? res_reg : (data_reg ^ ks);
  assign res_last = last_reg;

endmodule

>>> src/rc4_stream_cipher.sv
// rc4_stream_cipher: top level, apb key registers, output register, controller and datapath
// depends on rc4_pkg, rc4_ctrl, rc4_datapath
//
// channel   direction  signals                       contents
// s_*       in         s_tvalid s_tready s_tdata     data_byte in tdata[7:0],
//                      s_tlast                       last_byte on tlast
// m_*       out        m_tvalid m_tready m_tdata     out_byte in tdata[7:0],
//                      m_tlast                       out_last on tlast
// apb       in/out     psel penable pwrite paddr     key_low at 0x0, key_high at 0x8
//                      pwdata prdata pready
//
// inside a message each byte steps through these accesses of the permutation memory:
// read S[x], read S[y], write S[x] and read S[t], write S[y], then the result loads
// the first byte of a message first runs the key schedule: fill the
// permutation, one swap per entry for 256 swaps, then read S[x] to start the keystream
// reset (rst, synchronous) clears the indices and marks the key schedule as due
// a result stalled by m_tready waits in a result register; no byte is taken meanwhile
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] key_low, key_high;
  cmd_t        cmd;
  sts_t        sts;
  logic        i_last;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        cfg_wr;

  // apb registers, word select on paddr[3]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_KEY_HIGH: key_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      default:      prdata = '0;
    endcase
  end

  // status back to the controller
  always_comb begin
    sts          = '0;
    sts.in_valid = s_tvalid;
    sts.in_last  = s_tlast;
    sts.out_free = !m_tvalid || m_tready;
    sts.i_last   = i_last;
  end

  assign s_tready = cmd.in_ready;

  rc4_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rc4_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .key      ({key_high, key_low}),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .i_last   (i_last),
    .res_byte (res_byte),
    .res_last (res_last)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res_byte;
      m_tlast <= res_last;
    end
  end

  // a result is only loaded when the output register is empty or draining
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending output transfer");

  // one byte at a time: no transfer in the cycle right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a byte is in progress");

  // a drained output with no new load must go empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !cmd.out_load) |=> !m_tvalid)
    else $error("output transfer repeated");

endmodule
